// ===== rtl/core/tone_melody_sequencer_macros.svh =====
// Assertion macros used by the tone melody sequencer control (tms_ctrl).
`ifndef TONE_MELODY_SEQUENCER_MACROS_SVH
`define TONE_MELODY_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tms: implication check failed");

`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tms: next-cycle check failed");

`else

`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/tms_pkg.sv =====
// Types and constants of the tone melody sequencer.
package tms_pkg;

    localparam int SND_W     = 3;
    localparam int ELAPSED_W = 24;
    localparam int SIXT_W    = 16;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PLAY  = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_WRITE = 2'd3;

    localparam logic              CFG_IDX_SIXTEENTH = 1'b0;
    localparam logic [SIXT_W-1:0] SIXTEENTH_RESET   = 16'd125;

    typedef struct packed {
        logic [1:0]       action;
        logic [SND_W-1:0] sound;
        logic [3:0]       slot;
        logic             is_rest;
        logic [3:0]       pitch;
        logic [3:0]       octave;
        logic [7:0]       length_sixteenths;
        logic             last_in_melody;
    } t_in_item;

    typedef struct packed {
        logic       tone_on;
        logic [3:0] tone_pitch;
        logic [3:0] tone_octave;
        logic       playing;
        logic       request_dropped;
        logic       melody_done;
    } t_out_item;

    typedef struct packed {
        logic       is_rest;
        logic [3:0] pitch;
        logic [3:0] octave;
        logic [7:0] length;
        logic       last;
    } t_note;

    typedef struct packed {
        logic       on;
        logic [3:0] pitch;
        logic [3:0] octave;
    } t_tone;

endpackage

// ===== rtl/core/tms_note_ram.sv =====
// Note memory: one write port, two registered write-first read ports.
module tms_note_ram #(
    parameter int  DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  tms_pkg::t_note i_wdata,
    input  logic [AW-1:0]  i_raddr_a,
    input  logic [AW-1:0]  i_raddr_b,
    output tms_pkg::t_note o_rdata_a,
    output tms_pkg::t_note o_rdata_b
);

    tms_pkg::t_note r_mem [DEPTH];
    tms_pkg::t_note r_rd_a;
    tms_pkg::t_note r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= (i_we && i_waddr == i_raddr_a) ? i_wdata : r_mem[i_raddr_a];
        r_rd_b <= (i_we && i_waddr == i_raddr_b) ? i_wdata : r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== rtl/core/tms_queue_ram.sv =====
// Request queue storage: one write port, one registered write-first read port.
module tms_queue_ram #(
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tms_pkg::SND_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [tms_pkg::SND_W-1:0] o_rdata
);

    logic [tms_pkg::SND_W-1:0] r_mem [DEPTH];
    logic [tms_pkg::SND_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= (i_we && i_waddr == i_raddr) ? i_wdata : r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

// ===== rtl/core/tms_ctrl.sv =====
// Sequencer control: queue pointers, note timing and memory addressing.
`include "tone_melody_sequencer_macros.svh"

module tms_ctrl #(
    parameter int  SOUND_COUNT     = 8,
    parameter int  NOTES_PER_SOUND = 16,
    parameter int  QUEUE_DEPTH     = 8,
    localparam int NOTE_DEPTH      = SOUND_COUNT * NOTES_PER_SOUND,
    localparam int NAW             = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1,
    localparam int QAW             = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  tms_pkg::t_in_item          i_item,
    input  logic [tms_pkg::SIXT_W-1:0] i_sixteenth,
    input  tms_pkg::t_note             i_note_a,
    input  tms_pkg::t_note             i_note_b,
    input  logic [tms_pkg::SND_W-1:0]  i_q_next,
    output tms_pkg::t_out_item         o_result,
    output logic                       o_note_we,
    output logic [NAW-1:0]             o_note_waddr,
    output tms_pkg::t_note             o_note_wdata,
    output logic [NAW-1:0]             o_note_raddr_a,
    output logic [NAW-1:0]             o_note_raddr_b,
    output logic                       o_q_we,
    output logic [QAW-1:0]             o_q_waddr,
    output logic [tms_pkg::SND_W-1:0]  o_q_wdata,
    output logic [QAW-1:0]             o_q_raddr
);

    localparam int PW = (NOTES_PER_SOUND > 1) ? $clog2(NOTES_PER_SOUND) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [QAW-1:0]                r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_busy, n_busy;
    logic [tms_pkg::SND_W-1:0]     r_active, n_active;
    logic [tms_pkg::SND_W-1:0]     r_head_snd, n_head_snd;
    logic [PW-1:0]                 r_pos, n_pos;
    logic [tms_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    tms_pkg::t_tone                r_tone, n_tone;

    logic                          n_dropped;
    logic                          n_done;
    logic                          snd_ok;
    logic                          slot_ok;
    logic                          pos_last;
    logic [tms_pkg::ELAPSED_W-1:0] dur;
    logic [tms_pkg::ELAPSED_W-1:0] el_inc;

    function automatic logic [NAW-1:0] note_idx(input logic [tms_pkg::SND_W-1:0] s,
                                                input logic [PW-1:0] p);
        return NAW'(32'(s) * NOTES_PER_SOUND + 32'(p));
    endfunction

    function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] h);
        return (h == QAW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [QAW-1:0] q_tail(input logic [QAW-1:0] h,
                                              input logic [CW-1:0] c);
        int s;
        s = int'(h) + int'(c);
        if (s >= QUEUE_DEPTH) begin
            s = s - QUEUE_DEPTH;
        end
        return QAW'(s);
    endfunction

    function automatic tms_pkg::t_tone tone_of(input tms_pkg::t_note e);
        tms_pkg::t_tone t;
        t = '0;
        if (!e.is_rest) begin
            t.on     = 1'b1;
            t.pitch  = e.pitch;
            t.octave = e.octave;
        end
        return t;
    endfunction

    assign snd_ok   = 32'(i_item.sound) < SOUND_COUNT;
    assign slot_ok  = 32'(i_item.slot) < NOTES_PER_SOUND;
    assign pos_last = 32'(r_pos) == NOTES_PER_SOUND - 1;
    assign dur      = {16'd0, i_note_a.length} * {8'd0, i_sixteenth};
    assign el_inc   = r_elapsed + 1'b1;

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_busy       = r_busy;
        n_active     = r_active;
        n_head_snd   = r_head_snd;
        n_pos        = r_pos;
        n_elapsed    = r_elapsed;
        n_tone       = r_tone;
        n_dropped    = 1'b0;
        n_done       = 1'b0;
        o_note_we    = 1'b0;
        o_note_waddr = note_idx(i_item.sound, PW'(i_item.slot));
        o_note_wdata = '{is_rest: i_item.is_rest, pitch: i_item.pitch,
                         octave: i_item.octave, length: i_item.length_sixteenths,
                         last: i_item.last_in_melody};
        o_q_we       = 1'b0;
        o_q_waddr    = q_tail(r_head, r_count);
        o_q_wdata    = i_item.sound;
        if (i_acc) begin
            case (i_item.action)
                tms_pkg::ACT_TICK: begin
                    if (!r_busy) begin
                        if (r_count != '0) begin
                            n_active   = r_head_snd;
                            n_head     = q_inc(r_head);
                            n_head_snd = i_q_next;
                            n_count    = r_count - 1'b1;
                            n_busy     = 1'b1;
                            n_pos      = '0;
                            n_elapsed  = '0;
                            n_tone     = tone_of(i_note_a);
                        end
                    end else if (el_inc >= dur) begin
                        n_elapsed = el_inc - dur;
                        if (i_note_a.last || pos_last) begin
                            n_busy = 1'b0;
                            n_tone = '0;
                            n_done = 1'b1;
                        end else begin
                            n_pos  = r_pos + 1'b1;
                            n_tone = tone_of(i_note_b);
                        end
                    end else begin
                        n_elapsed = el_inc;
                    end
                end
                tms_pkg::ACT_PLAY: begin
                    if (snd_ok) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_dropped = 1'b1;
                        end else begin
                            o_q_we  = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_head_snd = i_item.sound;
                            end
                        end
                    end
                end
                tms_pkg::ACT_STOP: begin
                    n_head    = '0;
                    n_count   = '0;
                    n_busy    = 1'b0;
                    n_elapsed = '0;
                    n_tone    = '0;
                end
                tms_pkg::ACT_WRITE: begin
                    o_note_we = snd_ok && slot_ok;
                end
                default: begin
                    n_tone = r_tone;
                end
            endcase
        end
    end

    // next-state addressing: the read data is ready when the next item arrives
    always_comb begin
        o_q_raddr = q_inc(n_head);
        if (n_busy) begin
            o_note_raddr_a = note_idx(n_active, n_pos);
            if (32'(n_pos) == NOTES_PER_SOUND - 1) begin
                o_note_raddr_b = note_idx(n_active, n_pos);
            end else begin
                o_note_raddr_b = note_idx(n_active, n_pos + 1'b1);
            end
        end else begin
            o_note_raddr_a = note_idx(n_head_snd, '0);
            o_note_raddr_b = note_idx(n_head_snd, '0);
        end
    end

    always_comb begin
        o_result.tone_on         = n_tone.on;
        o_result.tone_pitch      = n_tone.pitch;
        o_result.tone_octave     = n_tone.octave;
        o_result.playing         = n_busy;
        o_result.request_dropped = n_dropped;
        o_result.melody_done     = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_busy     <= 1'b0;
            r_active   <= '0;
            r_head_snd <= '0;
            r_pos      <= '0;
            r_elapsed  <= '0;
            r_tone     <= '0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_busy     <= n_busy;
            r_active   <= n_active;
            r_head_snd <= n_head_snd;
            r_pos      <= n_pos;
            r_elapsed  <= n_elapsed;
            r_tone     <= n_tone;
        end
    end

    `TMS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `TMS_ASSERT_IMP(a_idle_silent, i_clk, i_rst_n, !r_busy, !r_tone.on)
    `TMS_ASSERT_NXT(a_full_holds, i_clk, i_rst_n, n_dropped, r_count == CW'(QUEUE_DEPTH))
    `TMS_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, i_acc && n_done, !r_busy && !r_tone.on)

endmodule

// ===== rtl/core/tone_melody_sequencer.sv =====
// Tone melody sequencer top level: APB register, item handshake, memories.
// Output: the result of an item is registered and is on the output in the cycle after its transfer.
// Throughput: one item per cycle while the output is not held; note reads for
// the next item come from the next state, so note and queue memory reads never stall.
// Reset: synchronous, active low; clears control state, sixteenth_ms to 125.
// Note and queue memories are not cleared and need no clearing pass.
module tone_melody_sequencer #(
    parameter int SOUND_COUNT     = 8,
    parameter int NOTES_PER_SOUND = 16,
    parameter int QUEUE_DEPTH     = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tms_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tms_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NOTE_DEPTH = SOUND_COUNT * NOTES_PER_SOUND;
    localparam int NAW        = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int QAW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [tms_pkg::SIXT_W-1:0] r_sixteenth;
    logic                       r_out_valid;
    tms_pkg::t_out_item         r_out;

    logic                       acc;
    logic                       cfg_wr;
    tms_pkg::t_out_item         result;
    tms_pkg::t_note             note_a;
    tms_pkg::t_note             note_b;
    logic [tms_pkg::SND_W-1:0]  q_next;
    logic                       note_we;
    logic [NAW-1:0]             note_waddr;
    tms_pkg::t_note             note_wdata;
    logic [NAW-1:0]             note_raddr_a;
    logic [NAW-1:0]             note_raddr_b;
    logic                       q_we;
    logic [QAW-1:0]             q_waddr;
    logic [tms_pkg::SND_W-1:0]  q_wdata;
    logic [QAW-1:0]             q_raddr;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && paddr[2] == tms_pkg::CFG_IDX_SIXTEENTH;
    assign prdata     = (paddr[2] == tms_pkg::CFG_IDX_SIXTEENTH) ? {16'd0, r_sixteenth} : '0;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sixteenth <= tms_pkg::SIXTEENTH_RESET;
        end else if (cfg_wr) begin
            r_sixteenth <= pwdata[tms_pkg::SIXT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= result;
        end
    end

    tms_ctrl #(
        .SOUND_COUNT     (SOUND_COUNT),
        .NOTES_PER_SOUND (NOTES_PER_SOUND),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_item         (i_in_item),
        .i_sixteenth    (r_sixteenth),
        .i_note_a       (note_a),
        .i_note_b       (note_b),
        .i_q_next       (q_next),
        .o_result       (result),
        .o_note_we      (note_we),
        .o_note_waddr   (note_waddr),
        .o_note_wdata   (note_wdata),
        .o_note_raddr_a (note_raddr_a),
        .o_note_raddr_b (note_raddr_b),
        .o_q_we         (q_we),
        .o_q_waddr      (q_waddr),
        .o_q_wdata      (q_wdata),
        .o_q_raddr      (q_raddr)
    );

    tms_note_ram #(
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .i_clk     (i_clk),
        .i_we      (note_we),
        .i_waddr   (note_waddr),
        .i_wdata   (note_wdata),
        .i_raddr_a (note_raddr_a),
        .i_raddr_b (note_raddr_b),
        .o_rdata_a (note_a),
        .o_rdata_b (note_b)
    );

    tms_queue_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_next)
    );

endmodule
